/* rtl/lpc_pkg.sv */
`default_nettype none

package lpc_pkg;

    // default line buffer depth in kept bytes
    localparam int MAX_LINE_DEF = 256;

    // command queue between front and back
    localparam int QDEPTH = 4;

    localparam logic [7:0] NEWLINE = 8'd10;

    // verdict codes
    localparam logic [1:0] V_EXACT   = 2'd0;
    localparam logic [1:0] V_FOLDED  = 2'd1;
    localparam logic [1:0] V_NOT     = 2'd2;
    localparam logic [1:0] V_INVALID = 2'd3;

    // what the front tells the back to do with one word
    typedef enum logic [1:0] {
        CMD_KEEP,
        CMD_SPACE,
        CMD_LINE,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    function automatic logic is_ws(input logic [7:0] b);
        return b inside {[8'd9:8'd13], 8'd32};
    endfunction

    // ASCII upper case to lower case, everything else unchanged
    function automatic logic [7:0] fold(input logic [7:0] b);
        return (b inside {[8'd65:8'd90]}) ? b + 8'd32 : b;
    endfunction

endpackage

`default_nettype wire

/* rtl/lpc_if.sv */
`default_nettype none

// text byte channel
interface lpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

// verdict channel
interface lpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

/* rtl/lpc_front.sv */
`default_nettype none

// Classifies each incoming word into a back-end command.
module lpc_front (
    lpc_in_if.sink          text,
    output logic            push_valid,
    input  wire logic       push_ready,
    output lpc_pkg::cmd_t   push_cmd
);

    assign text.ready = push_ready;
    assign push_valid = text.valid;

    // end of stream wins over the byte, then newline, then whitespace
    always_comb
    begin
        push_cmd.data = text.data_byte;
        if (text.stream_end)
        begin
            push_cmd.kind = lpc_pkg::CMD_END;
        end
        else if (text.data_byte == lpc_pkg::NEWLINE)
        begin
            push_cmd.kind = lpc_pkg::CMD_LINE;
        end
        else if (lpc_pkg::is_ws(text.data_byte))
        begin
            push_cmd.kind = lpc_pkg::CMD_SPACE;
        end
        else
        begin
            push_cmd.kind = lpc_pkg::CMD_KEEP;
        end
    end

endmodule

`default_nettype wire

/* rtl/lpc_queue.sv */
`default_nettype none

// Small command FIFO decoupling the front from the back.
module lpc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire lpc_pkg::cmd_t  push_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output lpc_pkg::cmd_t       pop_cmd
);

    localparam int PW = (lpc_pkg::QDEPTH > 1) ? $clog2(lpc_pkg::QDEPTH) : 1;
    localparam int NW = $clog2(lpc_pkg::QDEPTH + 1);

    lpc_pkg::cmd_t entry_reg [lpc_pkg::QDEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (fill_reg != NW'(lpc_pkg::QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(lpc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(lpc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/lpc_back.sv */
`default_nettype none

// Executes commands: stores kept bytes, compares the line at newline,
// holds the verdict in an output register.
module lpc_back #(
    parameter int MAX_LINE = lpc_pkg::MAX_LINE_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire lpc_pkg::cmd_t  pop_cmd,
    lpc_out_if.source           result
);

    localparam int AW = $clog2(MAX_LINE);
    localparam int CW = $clog2(MAX_LINE + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pending_reg, pending_next;
    logic          ovf_reg, ovf_next;
    logic          halted_reg, halted_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic          exact_ok_reg, exact_ok_next;
    logic          fold_ok_reg, fold_ok_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    verdict_reg, verdict_next;

    // line store
    logic [7:0]    line_mem [MAX_LINE];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    logic [CW-1:0] hi_full;
    logic [CW-1:0] last_idx;
    logic [7:0]    rd_a_reg;
    logic [7:0]    rd_b_reg;
    logic          can_emit;

    assign result.valid   = out_valid_reg;
    assign result.verdict = verdict_reg;

    assign can_emit  = !out_valid_reg || result.ready;
    assign wr_addr   = count_reg[AW-1:0];
    assign hi_full   = count_reg - CW'(1) - CW'(rd_idx_reg);
    assign rd_a_addr = rd_idx_reg;
    assign rd_b_addr = hi_full[AW-1:0];
    assign last_idx  = (count_reg >> 1) - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pending_next   = pending_reg;
        ovf_next       = ovf_reg;
        halted_next    = halted_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = 1'b0;
        exact_ok_next  = exact_ok_reg;
        fold_ok_next   = fold_ok_reg;
        out_valid_next = out_valid_reg && !result.ready;
        verdict_next   = verdict_reg;
        pop_ready      = 1'b0;
        wr_en          = 1'b0;

        // mirror pair compare on the registered read data, in the cycle after the reads
        if (cmp_vld_reg)
        begin
            if (rd_a_reg != rd_b_reg)
            begin
                exact_ok_next = 1'b0;
            end
            if (lpc_pkg::fold(rd_a_reg) != lpc_pkg::fold(rd_b_reg))
            begin
                fold_ok_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && halted_reg)
                begin
                    // halted: drain and drop
                    pop_ready = 1'b1;
                end
                else if (pop_valid)
                begin
                    case (pop_cmd.kind)
                        lpc_pkg::CMD_KEEP:
                        begin
                            pop_ready    = 1'b1;
                            pending_next = 1'b1;
                            if (count_reg < CW'(MAX_LINE))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        lpc_pkg::CMD_SPACE:
                        begin
                            pop_ready    = 1'b1;
                            pending_next = 1'b1;
                        end
                        lpc_pkg::CMD_LINE:
                        begin
                            if (count_reg == '0 || ovf_reg)
                            begin
                                if (can_emit)
                                begin
                                    pop_ready      = 1'b1;
                                    out_valid_next = 1'b1;
                                    verdict_next   = lpc_pkg::V_INVALID;
                                    halted_next    = 1'b1;
                                    count_next     = '0;
                                    pending_next   = 1'b0;
                                    ovf_next       = 1'b0;
                                end
                            end
                            else if (count_reg < CW'(2))
                            begin
                                // single byte is trivially exact
                                if (can_emit)
                                begin
                                    pop_ready      = 1'b1;
                                    out_valid_next = 1'b1;
                                    verdict_next   = lpc_pkg::V_EXACT;
                                    count_next     = '0;
                                    pending_next   = 1'b0;
                                    ovf_next       = 1'b0;
                                end
                            end
                            else
                            begin
                                pop_ready     = 1'b1;
                                rd_idx_next   = '0;
                                exact_ok_next = 1'b1;
                                fold_ok_next  = 1'b1;
                                state_next    = ST_CMP;
                            end
                        end
                        lpc_pkg::CMD_END:
                        begin
                            if (!pending_reg)
                            begin
                                pop_ready = 1'b1;
                            end
                            else if (can_emit)
                            begin
                                pop_ready      = 1'b1;
                                out_valid_next = 1'b1;
                                verdict_next   = lpc_pkg::V_INVALID;
                                halted_next    = 1'b1;
                                count_next     = '0;
                                pending_next   = 1'b0;
                                ovf_next       = 1'b0;
                            end
                        end
                        default:
                        begin
                            pop_ready = 1'b1;
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                // two reads per cycle: front index and its mirror
                cmp_vld_next = 1'b1;
                rd_idx_next  = rd_idx_reg + 1'b1;
                if (CW'(rd_idx_reg) == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last pair is compared this cycle
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    if (exact_ok_reg)
                    begin
                        verdict_next = lpc_pkg::V_EXACT;
                    end
                    else if (fold_ok_reg)
                    begin
                        verdict_next = lpc_pkg::V_FOLDED;
                    end
                    else
                    begin
                        verdict_next = lpc_pkg::V_NOT;
                    end
                    count_next   = '0;
                    pending_next = 1'b0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pending_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            halted_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            exact_ok_reg  <= 1'b1;
            fold_ok_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            verdict_reg   <= lpc_pkg::V_EXACT;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            ovf_reg       <= ovf_next;
            halted_reg    <= halted_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            exact_ok_reg  <= exact_ok_next;
            fold_ok_reg   <= fold_ok_next;
            out_valid_reg <= out_valid_next;
            verdict_reg   <= verdict_next;
        end
    end

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= pop_cmd.data;
        end
        rd_a_reg <= line_mem[rd_a_addr];
        rd_b_reg <= line_mem[rd_b_addr];
    end

endmodule

`default_nettype wire

/* rtl/line_palindrome_checker_unit.sv */
// Line palindrome checker. Text bytes arrive on the text channel; whitespace
// (9 to 13 and 32) is dropped and the other bytes of a line are stored, up to
// MAX_LINE of them. A newline closes the line and one verdict word leaves on
// the result channel: 0 exact palindrome, 1 palindrome only with ASCII case
// folded, 2 not a palindrome, 3 invalid (empty line, line longer than
// MAX_LINE, or stream end with a pending line). After verdict 3 the block
// swallows all input and gives no result until reset. Words pass a
// 4-entry command queue; a closing newline with two or more kept bytes
// holds the back end in the mirror compare, which reads two bytes per
// cycle from the line store. The front keeps taking bytes while the queue
// has room, and the verdict register lets the next line proceed while a
// result waits.
`default_nettype none

module line_palindrome_checker_unit #(
    parameter int MAX_LINE = lpc_pkg::MAX_LINE_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lpc_in_if.sink      text,
    lpc_out_if.source   result
);

    logic          push_valid;
    logic          push_ready;
    lpc_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    lpc_pkg::cmd_t pop_cmd;

    lpc_front u_front (
        .text       (text),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    lpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    lpc_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .result    (result)
    );

endmodule

`default_nettype wire

/* rtl/lpc_checker.sv */
`default_nettype none

module lpc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [1:0] verdict
);

    logic inv_taken;
    assign inv_taken = result_valid && result_ready && (verdict == lpc_pkg::V_INVALID);

    // stalled verdict word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(verdict))
        else $error("verdict changed or dropped while stalled");

    // invalid verdict halts: nothing follows right after
    a_halt1: assert property (@(posedge clk) disable iff (!rst_n)
        inv_taken |=> !result_valid)
        else $error("result after invalid verdict");

    a_halt2: assert property (@(posedge clk) disable iff (!rst_n)
        inv_taken |=> ##1 !result_valid)
        else $error("result two cycles after invalid verdict");

    // reset leaves no verdict pending
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid out of reset");

endmodule

bind line_palindrome_checker_unit lpc_checker u_lpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .verdict      (result.verdict)
);

`default_nettype wire

/* test/palindrome_verdict_checker.sv */
`timescale 1ns / 100ps

// Watches the text and verdict channels, keeps its own copy of the line state
// and compares every verdict word with the oldest predicted one.
module palindrome_verdict_checker (
    input  logic clk,
    input  logic rst_n,
    lpc_in_if    text,
    lpc_out_if   result,
    output int   fail_count,
    output int   verdicts_waiting
);

    localparam int DEPTH = lpc_pkg::MAX_LINE_DEF;

    // predicted line state
    logic [7:0] line_buf [DEPTH];
    logic [8:0] kept_n;
    logic       line_open;
    logic       too_long;
    logic       halted;

    logic [1:0] expected_verdicts [$];
    int         error_total = 0;
    int         waiting_n = 0;
    logic [1:0] want;

    assign fail_count       = error_total;
    assign verdicts_waiting = waiting_n;

    function automatic logic blank_byte(input logic [7:0] b);
        return (b >= 8'd9 && b <= 8'd13) || b == 8'd32;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
    endfunction

    // mirror compare of the kept bytes, case kept and case folded
    function automatic logic [1:0] line_verdict();
        logic exact_ok;
        logic fold_ok;
        int   i;
        exact_ok = 1'b1;
        fold_ok  = 1'b1;
        for (i = 0; i < int'(kept_n) / 2; i++)
        begin
            if (line_buf[i] != line_buf[int'(kept_n) - 1 - i])
                exact_ok = 1'b0;
            if (to_lower(line_buf[i]) != to_lower(line_buf[int'(kept_n) - 1 - i]))
                fold_ok = 1'b0;
        end
        if (exact_ok)
            return lpc_pkg::V_EXACT;
        if (fold_ok)
            return lpc_pkg::V_FOLDED;
        return lpc_pkg::V_NOT;
    endfunction

    // advance the predicted state by one accepted text word
    task automatic absorb_word(input logic [7:0] b, input logic fin);
        if (halted)
            return;
        if (fin)
        begin
            // end of stream only matters with a line still open
            if (line_open)
            begin
                halted    = 1'b1;
                kept_n    = '0;
                line_open = 1'b0;
                too_long  = 1'b0;
                expected_verdicts.push_back(lpc_pkg::V_INVALID);
            end
            return;
        end
        if (b != lpc_pkg::NEWLINE)
        begin
            line_open = 1'b1;
            if (!blank_byte(b))
            begin
                if (int'(kept_n) < DEPTH)
                begin
                    line_buf[kept_n] = b;
                    kept_n = kept_n + 9'd1;
                end
                else
                    too_long = 1'b1;
            end
            return;
        end
        // newline: empty or overflowed line is invalid and halts
        if (kept_n == '0 || too_long)
        begin
            expected_verdicts.push_back(lpc_pkg::V_INVALID);
            halted = 1'b1;
        end
        else
            expected_verdicts.push_back(line_verdict());
        kept_n    = '0;
        line_open = 1'b0;
        too_long  = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_n    = '0;
            line_open = 1'b0;
            too_long  = 1'b0;
            halted    = 1'b0;
            expected_verdicts.delete();
            waiting_n = 0;
        end
        else
        begin
            if (text.valid && text.ready)
                absorb_word(text.data_byte, text.stream_end);
            if (result.valid && result.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    if (error_total < 10)
                        $display("%0t: verdict word %0d with none predicted",
                                 $realtime, result.verdict);
                    error_total++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (result.verdict !== want)
                    begin
                        if (error_total < 10)
                            $display("%0t: verdict mismatch, expected %0d got %0d",
                                     $realtime, want, result.verdict);
                        error_total++;
                    end
                end
            end
            waiting_n = expected_verdicts.size();
        end
    end

endmodule

/* test/line_palindrome_checker_unit_tb.sv */
`timescale 1ns / 100ps

module line_palindrome_checker_unit_tb;

    typedef logic [7:0] byte_q_t [$];

    typedef enum logic [1:0] {
        SHAPE_EXACT,
        SHAPE_FOLDED,
        SHAPE_NEAR,
        SHAPE_NOISE
    } line_shape_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_PATTERN,
        RX_SPARSE,
        RX_COIN
    } rx_mode_t;

    typedef enum logic [1:0] {
        HALT_EMPTY,
        HALT_OVERFLOW,
        HALT_OPEN_END
    } halt_kind_t;

    localparam int RANDOM_WORDS = 100;
    localparam logic [7:0] BLANKS [5] = '{8'd9, 8'd11, 8'd12, 8'd13, 8'd32};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int verdicts_waiting;
    int words_sent = 0;
    int burst_left = 0;

    lpc_in_if  text_ch ();
    lpc_out_if result_ch ();

    line_palindrome_checker_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    palindrome_verdict_checker verdict_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .text             (text_ch),
        .result           (result_ch),
        .fail_count       (fail_count),
        .verdicts_waiting (verdicts_waiting)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // verdict receiver: stall pattern changes between runs of random length
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [31:0] rx_mask = '0;

    initial
        result_ch.ready = 1'b0;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
            rx_mask = $urandom;
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:    result_ch.ready <= 1'b1;
            RX_PATTERN: result_ch.ready <= rx_mask[rx_left % 32];
            RX_SPARSE:  result_ch.ready <= ($urandom_range(0, 3) == 0);
            default:    result_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    function automatic logic [7:0] rand_blank();
        return BLANKS[$urandom_range(0, 4)];
    endfunction

    // any byte that is kept: not whitespace, not newline
    function automatic logic [7:0] rand_glyph();
        logic [7:0] b;
        b = 8'($urandom);
        while ((b >= 8'd9 && b <= 8'd13) || b == 8'd32)
            b = 8'($urandom);
        return b;
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] b;
        b = 8'd65 + 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? b : b + 8'd32;
    endfunction

    // kept bytes of one line in the given shape
    function automatic byte_q_t make_line(input int len, input line_shape_t shape);
        byte_q_t    k;
        logic [7:0] b;
        int         i;
        for (i = 0; i < len; i++)
            k.push_back(8'h00);
        for (i = 0; i < (len + 1) / 2; i++)
        begin
            b = (shape == SHAPE_FOLDED) ? rand_letter() : rand_glyph();
            k[i] = b;
            k[len - 1 - i] = (shape == SHAPE_FOLDED && $urandom_range(0, 1)) ? b ^ 8'h20 : b;
        end
        if (shape == SHAPE_NEAR)
            k[$urandom_range(0, len - 1)] = rand_glyph();
        if (shape == SHAPE_NOISE)
            for (i = 0; i < len; i++)
                k[i] = rand_glyph();
        return k;
    endfunction

    // scatter whitespace between the kept bytes
    function automatic byte_q_t with_blanks(input byte_q_t k);
        byte_q_t q;
        int      i;
        for (i = 0; i < k.size(); i++)
        begin
            if ($urandom_range(0, 5) == 0)
                q.push_back(rand_blank());
            q.push_back(k[i]);
        end
        if ($urandom_range(0, 3) == 0)
            q.push_back(rand_blank());
        return q;
    endfunction

    // one text word, sent in bursts with random gaps between them
    task automatic send_word(input logic [7:0] b, input logic fin);
        if (burst_left == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        text_ch.valid      <= 1'b1;
        text_ch.data_byte  <= b;
        text_ch.stream_end <= fin;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_bytes(input byte_q_t q);
        int i;
        for (i = 0; i < q.size(); i++)
            send_word(q[i], 1'b0);
    endtask

    task automatic send_line(input byte_q_t q);
        send_bytes(q);
        send_word(lpc_pkg::NEWLINE, 1'b0);
    endtask

    initial
    begin
        int          goal;
        int          len;
        int          i;
        line_shape_t shape;
        byte_q_t     q;

        text_ch.valid      = 1'b0;
        text_ch.data_byte  = '0;
        text_ch.stream_end = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: end of stream with nothing pending gives no verdict
        send_word(8'hFF, 1'b1);
        // single byte, zero and top bytes, case folding edges
        send_line('{8'h61});
        send_line('{8'h00, 8'hFF, 8'h00});
        send_line('{8'h41, 8'h62, 8'h20, 8'h61});
        send_line('{8'h5A, 8'h09, 8'h7A, 8'h0D});
        send_line('{8'h5B, 8'h7B});
        send_line('{8'h40, 8'h60});
        send_line('{8'hC1, 8'hE1});
        // bytes next to the whitespace range are kept
        send_line('{8'h08, 8'h0E, 8'h1F, 8'h21, 8'h21, 8'h1F, 8'h0E, 8'h08});
        send_line('{8'h0B, 8'h0C, 8'h20, 8'h71});
        send_word(lpc_pkg::NEWLINE, 1'b1);
        send_line('{8'h61, 8'h62, 8'h61, 8'h41});
        send_line('{8'h61, 8'h62});
        // a line that just fills the buffer
        send_line(with_blanks(make_line(256, SHAPE_FOLDED)));
        send_word(8'h00, 1'b1);

        // random lines, mostly short; no empty line until the end
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal)
        begin
            if ($urandom_range(0, 99) < 8)
                send_word(8'($urandom), 1'b1);
            else
            begin
                shape = line_shape_t'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 3)
                    len = $urandom_range(100, 256);
                else if ($urandom_range(0, 9) < 4)
                    len = $urandom_range(1, 3);
                else
                    len = $urandom_range(1, 12);
                send_line(with_blanks(make_line(len, shape)));
            end
        end

        // one halting case, then words that must be swallowed
        case (halt_kind_t'($urandom_range(0, 2)))
            HALT_EMPTY:
            begin
                q.delete();
                repeat ($urandom_range(0, 3)) q.push_back(rand_blank());
                send_line(q);
            end
            HALT_OVERFLOW:
                send_line(with_blanks(make_line($urandom_range(257, 260), SHAPE_EXACT)));
            default:
            begin
                if ($urandom_range(0, 1))
                    send_bytes(with_blanks(make_line($urandom_range(1, 5), SHAPE_EXACT)));
                else
                    send_word(rand_blank(), 1'b0);
                send_word(8'($urandom), 1'b1);
            end
        endcase
        for (i = 0; i < 8; i++)
            send_word(8'($urandom), 1'($urandom_range(0, 1)));
        send_line('{8'h61, 8'h61});
        send_word(8'h20, 1'b0);
        send_word(8'h00, 1'b1);
        text_ch.valid <= 1'b0;

        // drain, then let the back end settle
        while (verdicts_waiting != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (fail_count == 0 && verdicts_waiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
